[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define GPE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define GPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg
// Types, constants and command/status structures of the Golomb estimator.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int HISTORY_DEPTH  = 3;

    localparam int SAMPLE_W   = 16;
    localparam int ORDER_W    = 3;
    localparam int QBITS_W    = 5;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int K_W        = 4;
    localparam int FRAME_W    = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_MAX   = 3'd4;
    localparam logic [QBITS_W-1:0] QBITS_RESET = 5'd16;
    localparam logic [QBITS_W-1:0] QBITS_MAX   = 5'd16;
    localparam logic [QBITS_W-1:0] QBITS_MIN   = 5'd1;
    localparam logic [CHAN_W-1:0]  CHAN_RESET  = 2'd1;
    localparam logic [CHAN_W-1:0]  CHAN_STEREO = 2'd2;
    localparam logic [FRAME_W-1:0] FRAME_MAX   = 3'd7;
    localparam logic [K_W-1:0]     K_MIN       = 4'd1;
    localparam logic [K_W-1:0]     K_MAX       = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER = 2'd0,
        CFG_LOSSY = 2'd1,
        CFG_QBITS = 2'd2,
        CFG_CHAN  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic k_step;
        logic publish;
    } gpe_cmd_t;

    typedef struct packed {
        logic last;
        logic k_found;
        logic out_busy;
    } gpe_sts_t;

endpackage

[src/golomb_parameter_estimator.sv]
// ----------------------------------------------------------------------------
// golomb_parameter_estimator
// Fixed polynomial predictor with running error statistics; emits the
// Golomb parameter M = 2^k on the sample marked last.
//
//   channel   dir   payload
//   s_axis    in    tdata: sample[15:0]; tlast: last_sample
//   m_axis    out   tdata: golomb_m[15:0], m_exponent[19:16]; tuser: overflow
//   cfg       in    cfg_index selects order, lossy, quant bits, channels
//
// Each sample passes through capture, then one predict-and-accumulate step.
// A last sample adds an exponent search, one k per cycle.
// The result sits in a one-entry output register; samples keep flowing while
// it waits, but a following last sample holds in search until it is taken.
// Reset is asynchronous: configuration returns to defaults, statistics clear.
// ----------------------------------------------------------------------------
module golomb_parameter_estimator #(
    parameter int COUNT_BITS = gpe_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [gpe_pkg::SAMPLE_W-1:0]          s_axis_tdata,  // sample
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [gpe_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // golomb_m, m_exponent
    output logic                                  m_axis_tuser,  // count_overflow
    input  logic                                  cfg_we,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]        cfg_data
);

    gpe_pkg::gpe_cmd_t           cmd;
    gpe_pkg::gpe_sts_t           sts;
    logic [gpe_pkg::SAMPLE_W-1:0] golomb_m;
    logic [gpe_pkg::K_W-1:0]      m_exponent;

    gpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gpe_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (s_axis_tdata),
        .last_sample    (s_axis_tlast),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .golomb_m       (golomb_m),
        .m_exponent     (m_exponent),
        .count_overflow (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, m_exponent, golomb_m};

endmodule

[src/gpe_dp.sv]
// ----------------------------------------------------------------------------
// gpe_dp
// Datapath: configuration, predictor history, error accumulation, exponent
// search and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpe_dp #(
    parameter int COUNT_BITS = gpe_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [gpe_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    input  gpe_pkg::gpe_cmd_t                   cmd,
    output gpe_pkg::gpe_sts_t                   sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [gpe_pkg::SAMPLE_W-1:0]        golomb_m,
    output logic [gpe_pkg::K_W-1:0]             m_exponent,
    output logic                                count_overflow
);

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SUM_W = COUNT_BITS + 17;
    localparam int THR_W = COUNT_BITS + 16;
    localparam int SW    = gpe_pkg::SAMPLE_W;
    localparam int HD    = gpe_pkg::HISTORY_DEPTH;

    logic [gpe_pkg::ORDER_W-1:0] order_reg;
    logic                        lossy_reg;
    logic [gpe_pkg::QBITS_W-1:0] qbits_reg;
    logic [gpe_pkg::CHAN_W-1:0]  chan_reg;

    logic signed [SW-1:0] sample_reg;
    logic                 last_reg;

    logic signed [SW-1:0]          hist_reg [2][HD];
    logic                          phase_reg;
    logic [gpe_pkg::FRAME_W-1:0]   frame_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;
    logic [gpe_pkg::K_W-1:0]       k_reg;
    logic [THR_W-1:0]              thr_reg;

    logic                          out_valid_reg;
    logic [SW-1:0]                 out_m_reg;
    logic [gpe_pkg::K_W-1:0]       out_k_reg;
    logic                          out_ovf_reg;

    logic [gpe_pkg::ORDER_W-1:0] order_eff;
    logic [gpe_pkg::QBITS_W-1:0] qbits_eff;
    logic [gpe_pkg::QBITS_W-1:0] shift5;
    logic [3:0]                  shift;
    logic                        stereo;
    logic                        ch;
    logic                        warmup;
    logic signed [SW-1:0]        h0;
    logic signed [SW-1:0]        h1;
    logic signed [SW-1:0]        h2;
    logic signed [SW-1:0]        pred;
    logic signed [SW-1:0]        resid;
    logic signed [SW-1:0]        src;
    logic signed [SW-1:0]        q;
    logic signed [SW-1:0]        q_shl;
    logic signed [SW-1:0]        val;
    logic signed [SW:0]          val_ext;
    logic signed [SW:0]          err;
    logic signed [SW-1:0]        newh;
    logic                        cnt_full;
    logic [CNT_W-1:0]            count_next;
    logic                        sum_nonpos;

    always_comb
    begin
        order_eff = (order_reg > gpe_pkg::ORDER_MAX) ? gpe_pkg::ORDER_MAX : order_reg;
        if (qbits_reg < gpe_pkg::QBITS_MIN)
            qbits_eff = gpe_pkg::QBITS_MIN;
        else if (qbits_reg > gpe_pkg::QBITS_MAX)
            qbits_eff = gpe_pkg::QBITS_MAX;
        else
            qbits_eff = qbits_reg;
        shift5 = gpe_pkg::QBITS_MAX - qbits_eff;
        shift  = shift5[3:0];
        stereo = (chan_reg == gpe_pkg::CHAN_STEREO);
        ch     = stereo & phase_reg;
        warmup = (frame_reg < order_eff);
        h0     = hist_reg[ch][0];
        h1     = hist_reg[ch][1];
        h2     = hist_reg[ch][2];
        case (order_eff)
            3'd1:    pred = h0;
            3'd2:    pred = (h0 + h0) - h1;
            3'd3:    pred = ((h0 + h0 + h0) - (h1 + h1 + h1)) + h2;
            3'd4:    pred = (h0 + h0) - h1;
            default: pred = '0;
        endcase
        resid   = sample_reg - pred;
        src     = warmup ? sample_reg : resid;
        q       = src >>> shift;
        q_shl   = q << shift;
        val     = lossy_reg ? q : src;
        val_ext = {val[SW-1], val};
        if (warmup || !val[SW-1])
            err = val_ext;
        else
            err = -val_ext;
        if (!lossy_reg)
            newh = sample_reg;
        else if (warmup)
            newh = q_shl;
        else
            newh = pred + q_shl;
        cnt_full   = count_reg[COUNT_BITS];
        count_next = cnt_full ? count_reg : count_reg + CNT_W'(1);
        sum_nonpos = sum_reg[SUM_W-1] || (sum_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= gpe_pkg::ORDER_RESET;
            lossy_reg <= 1'b0;
            qbits_reg <= gpe_pkg::QBITS_RESET;
            chan_reg  <= gpe_pkg::CHAN_RESET;
        end
        else if (cfg_we)
        begin
            case (gpe_pkg::cfg_reg_t'(cfg_index))
                gpe_pkg::CFG_ORDER: order_reg <= cfg_data[gpe_pkg::ORDER_W-1:0];
                gpe_pkg::CFG_LOSSY: lossy_reg <= cfg_data[0];
                gpe_pkg::CFG_QBITS: qbits_reg <= cfg_data[gpe_pkg::QBITS_W-1:0];
                gpe_pkg::CFG_CHAN:  chan_reg  <= cfg_data[gpe_pkg::CHAN_W-1:0];
                default:            order_reg <= order_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sample_reg <= sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            phase_reg <= 1'b0;
            frame_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= gpe_pkg::K_MIN;
            thr_reg   <= '0;
            for (int c = 0; c < 2; c++)
                for (int i = 0; i < HD; i++)
                    hist_reg[c][i] <= '0;
        end
        else
        begin
            if (cmd.capture)
                last_reg <= last_sample;
            if (cmd.exec)
            begin
                if (cnt_full)
                    ovf_reg <= 1'b1;
                else
                    sum_reg <= sum_reg + {{(SUM_W-SW-1){err[SW]}}, err};
                count_reg <= count_next;
                k_reg     <= gpe_pkg::K_MIN;
                thr_reg   <= {{(THR_W-CNT_W){1'b0}}, count_next} << 1;
                if (last_reg)
                begin
                    phase_reg <= 1'b0;
                    frame_reg <= '0;
                    for (int c = 0; c < 2; c++)
                        for (int i = 0; i < HD; i++)
                            hist_reg[c][i] <= '0;
                end
                else
                begin
                    for (int i = HD - 1; i > 0; i--)
                        hist_reg[ch][i] <= hist_reg[ch][i-1];
                    hist_reg[ch][0] <= newh;
                    if (!stereo || ch)
                    begin
                        if (frame_reg < gpe_pkg::FRAME_MAX)
                            frame_reg <= frame_reg + 3'd1;
                        phase_reg <= 1'b0;
                    end
                    else
                        phase_reg <= 1'b1;
                end
            end
            if (cmd.k_step)
            begin
                k_reg   <= k_reg + 4'd1;
                thr_reg <= thr_reg << 1;
            end
            if (cmd.publish)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_m_reg   <= SW'(1) << k_reg;
            out_k_reg   <= k_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        sts.last     = last_reg;
        sts.k_found  = sum_nonpos || (k_reg == gpe_pkg::K_MAX) ||
                       ($unsigned(sum_reg) <= {1'b0, thr_reg});
        sts.out_busy = out_valid_reg & ~out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign golomb_m       = out_m_reg;
    assign m_exponent     = out_k_reg;
    assign count_overflow = out_ovf_reg;

    `GPE_ASSERT(a_k_range, (k_reg >= gpe_pkg::K_MIN) && (k_reg <= gpe_pkg::K_MAX), "k out of range")
    `GPE_ASSERT(a_count_bound, !(count_reg[COUNT_BITS] && (|count_reg[COUNT_BITS-1:0])), "count past bound")
    `GPE_ASSERT(a_m_pow2, !out_valid_reg || (out_m_reg == (SW'(1) << out_k_reg)), "M not 2^k")

endmodule

[src/gpe_ctrl.sv]
// ----------------------------------------------------------------------------
// gpe_ctrl
// Controller: sequences capture, execute and, for a last sample, the exponent search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output gpe_pkg::gpe_cmd_t cmd,
    input  gpe_pkg::gpe_sts_t sts
);

    gpe_pkg::state_t state_reg;
    gpe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gpe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpe_pkg::ST_IDLE:
                if (in_valid)
                    state_next = gpe_pkg::ST_EXEC;
            gpe_pkg::ST_EXEC:
                state_next = sts.last ? gpe_pkg::ST_SEARCH : gpe_pkg::ST_IDLE;
            gpe_pkg::ST_SEARCH:
                if (sts.k_found && !sts.out_busy)
                    state_next = gpe_pkg::ST_IDLE;
            default:
                state_next = gpe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            gpe_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            gpe_pkg::ST_EXEC:
                cmd.exec = 1'b1;
            gpe_pkg::ST_SEARCH:
            begin
                cmd.k_step  = ~sts.k_found;
                cmd.publish = sts.k_found & ~sts.out_busy;
            end
            default:
                cmd = '0;
        endcase
    end

    `GPE_ASSERT_NEXT(a_exec_after_accept, in_valid && in_ready, state_reg == gpe_pkg::ST_EXEC, "accept not followed by execute")
    `GPE_ASSERT_NEXT(a_idle_after_publish, cmd.publish, state_reg == gpe_pkg::ST_IDLE, "publish not followed by idle")

endmodule
